@@ design/sdspi_pkg.sv @@
`timescale 1ns / 1ps
package sdspi_pkg;
	localparam int unsigned BLOCK_BYTES = 512;

	typedef enum logic [2:0] {
		CMD_INIT = 3'd0, CMD_READ = 3'd1, CMD_WSTART = 3'd2, CMD_WBYTE = 3'd3,
		CMD_WFINISH = 3'd4, CMD_RX = 3'd5, CMD_TICK = 3'd6, CMD_NONE = 3'd7
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_CMD, PH_CLK, PH_OCR8, PH_OCR58, PH_TICK, PH_INIT_END,
		PH_TOKEN, PH_DATA, PH_OK_END, PH_ERR_END, PH_WS_TOKEN, PH_WB,
		PH_WF_PAD, PH_WF_RESP, PH_WF_BUSY
	} phase_t;

	typedef enum logic [2:0] {
		K_CMD0, K_CMD8, K_PROBE, K_LOOP, K_CMD58, K_CMD16, K_CMD17, K_CMD24
	} ret_t;

	localparam logic [3:0] KIND_MMC   = 4'h1;
	localparam logic [3:0] KIND_SD1   = 4'h2;
	localparam logic [3:0] KIND_SD2   = 4'h4;
	localparam logic [3:0] KIND_BLOCK = 4'h8;

	localparam logic [7:0] OP_RESET    = 8'h40;
	localparam logic [7:0] OP_MMC_INIT = 8'h41;
	localparam logic [7:0] OP_IFCOND   = 8'h48;
	localparam logic [7:0] OP_BLKLEN   = 8'h50;
	localparam logic [7:0] OP_READ     = 8'h51;
	localparam logic [7:0] OP_WRITE    = 8'h58;
	localparam logic [7:0] OP_APP      = 8'h77;
	localparam logic [7:0] OP_OCR      = 8'h7A;
	localparam logic [7:0] OP_SD_INIT  = 8'hE9;

	localparam logic [1:0] REG_POLL  = 2'd0;
	localparam logic [1:0] REG_RETRY = 2'd1;
	localparam logic [1:0] REG_TOKEN = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ERR   = 2'd1;
	localparam logic [1:0] ST_NOINIT = 2'd2;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] sector;
		logic [8:0]  byte_offset;
		logic [9:0]  byte_count;
		logic [7:0]  data_byte;
		logic [7:0]  rx_byte;
	} in_item_t;

	// classified item: front computes range check up front
	typedef struct packed {
		cmd_t        command;
		logic [31:0] sector;
		logic [8:0]  byte_offset;
		logic [9:0]  byte_count;
		logic [7:0]  data_byte;
		logic [7:0]  rx_byte;
		logic        range_bad;
	} cls_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       chip_selected;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       wait_tick;
		logic       done_res;
		logic [1:0] status;
		logic [3:0] card_kind;
	} out_item_t;
endpackage

@@ design/sdspi_if.sv @@
`timescale 1ns / 1ps
interface sdspi_in_if;
	logic                 valid;
	logic                 ready;
	sdspi_pkg::in_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sdspi_out_if;
	logic                 valid;
	logic                 ready;
	sdspi_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/sdspi_front.sv @@
`timescale 1ns / 1ps
module sdspi_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sdspi_pkg::in_item_t    in_item,
	output logic                   q_valid,
	input  logic                   q_ready,
	output sdspi_pkg::cls_item_t   q_item
);
	import sdspi_pkg::*;

	// two-entry queue
	cls_item_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cls_item_t  cls;
	logic       push, pop;

	always_comb begin
		cls.command     = in_item.command;
		cls.sector      = in_item.sector;
		cls.byte_offset = in_item.byte_offset;
		cls.byte_count  = in_item.byte_count;
		cls.data_byte   = in_item.data_byte;
		cls.rx_byte     = in_item.rx_byte;
		cls.range_bad   = ({2'b0, in_item.byte_offset} + {1'b0, in_item.byte_count})
			> 11'(BLOCK_BYTES);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ design/sdspi_back.sv @@
`timescale 1ns / 1ps
module sdspi_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [15:0]          cfg_data,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  sdspi_pkg::cls_item_t q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sdspi_pkg::out_item_t out_item
);
	import sdspi_pkg::*;

	logic [7:0]  poll_lim_q;
	logic [15:0] retry_lim_q, token_lim_q;

	phase_t      phase_q, phase_d;
	logic [3:0]  sub_q, sub_d;
	logic [9:0]  bc_q, bc_d;
	logic [15:0] poll_q, poll_d, retry_q, retry_d;
	logic [3:0]  ctype_q, ctype_d, ikind_q, ikind_d;
	logic [7:0]  pcmd_q, pcmd_d, wire_q, wire_d;
	logic [31:0] parg_q, parg_d;
	logic [9:0]  wrem_q, wrem_d;
	logic [1:0]  ocr_q, ocr_d;
	ret_t        ret_q, ret_d;
	logic [8:0]  rdf_q, rdf_d;
	logic [9:0]  rdc_q, rdc_d;
	logic        pfx_q, pfx_d, cs_q, cs_d;

	out_item_t   r;
	out_item_t   obuf_q;
	logic        ovalid_q;
	logic        step;

	assign q_ready  = !ovalid_q || out_ready;
	assign step     = q_valid && q_ready;
	assign out_valid = ovalid_q;
	assign out_item = obuf_q;

	function automatic logic [7:0] cmd_byte(input logic [3:0] st, input logic [7:0] wc,
		input logic [31:0] a);
		logic [7:0] b;
		case (st)
			4'd2: b = wc;
			4'd3: b = a[31:24];
			4'd4: b = a[23:16];
			4'd5: b = a[15:8];
			4'd6: b = a[7:0];
			default: b = (wc == OP_RESET) ? 8'h95 : (wc == OP_IFCOND) ? 8'h87 : 8'h01;
		endcase
		return b;
	endfunction

	always_comb begin
		logic [7:0]  rx;
		logic        do_done, do_init_fin, do_err, do_loop, do_raw;
		logic [7:0]  cs_op;
		logic [31:0] cs_arg;
		ret_t        cs_k;
		logic        do_cmd;
		logic [31:0] addr;
		logic [15:0] pdec;
		logic [9:0]  bcn;
		logic [10:0] rd_end;
		logic [7:0]  resp;

		phase_d = phase_q; sub_d = sub_q; bc_d = bc_q; poll_d = poll_q;
		retry_d = retry_q; ctype_d = ctype_q; ikind_d = ikind_q; pcmd_d = pcmd_q;
		wire_d = wire_q; parg_d = parg_q; wrem_d = wrem_q; ocr_d = ocr_q;
		ret_d = ret_q; rdf_d = rdf_q; rdc_d = rdc_q; pfx_d = pfx_q; cs_d = cs_q;
		r = '0;
		rx = q_item.rx_byte;
		do_done = 1'b0; do_init_fin = 1'b0; do_err = 1'b0; do_loop = 1'b0;
		do_raw = 1'b0; do_cmd = 1'b0;
		cs_op = 8'h00; cs_arg = 32'h0; cs_k = K_CMD0;
		resp = rx;
		pdec = 16'h0; bcn = 10'h0;
		rd_end = {2'b0, rdf_q} + {1'b0, rdc_q};
		addr = ctype_q[3] ? q_item.sector : {q_item.sector[22:0], 9'b0};

		if (phase_q == PH_IDLE && q_item.command <= CMD_WFINISH) begin
			case (q_item.command)
				CMD_INIT: begin
					ikind_d = '0; cs_d = 1'b0; bc_d = 10'd10; phase_d = PH_CLK;
					r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
				end
				CMD_READ: begin
					if (q_item.range_bad) begin
						r.done_res = 1'b1; r.status = ST_ERR; phase_d = PH_IDLE;
					end else begin
						rdf_d = q_item.byte_offset; rdc_d = q_item.byte_count;
						do_cmd = 1'b1; cs_op = OP_READ; cs_arg = addr; cs_k = K_CMD17;
					end
				end
				CMD_WSTART: begin
					do_cmd = 1'b1; cs_op = OP_WRITE; cs_arg = addr; cs_k = K_CMD24;
				end
				CMD_WBYTE: begin
					if (wrem_q == 10'd0) begin
						r.done_res = 1'b1; r.status = ST_OK;
					end else begin
						wrem_d = wrem_q - 10'd1; phase_d = PH_WB;
						r.tx_valid = 1'b1; r.tx_byte = q_item.data_byte;
					end
				end
				default: begin
					bc_d = wrem_q + 10'd2; wrem_d = '0; phase_d = PH_WF_PAD;
					r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
				end
			endcase
		end else if (q_item.command == CMD_RX && phase_q != PH_IDLE && phase_q != PH_TICK) begin
			case (phase_q)
				PH_CMD: begin
					if (sub_q == 4'd0) begin
						cs_d = 1'b1; sub_d = 4'd1; r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end else if (sub_q < 4'd7) begin
						sub_d = sub_q + 4'd1; r.tx_valid = 1'b1;
						r.tx_byte = cmd_byte(sub_q + 4'd1, wire_q, pfx_q ? 32'h0 : parg_q);
					end else if (sub_q == 4'd7) begin
						sub_d = 4'd8; poll_d = {8'h0, poll_lim_q};
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end else begin
						pdec = {8'h0, poll_q[7:0] - 8'd1};
						if (rx[7]) poll_d = pdec;
						if (rx[7] && pdec != 16'h0) begin
							r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
						end else if (pfx_q) begin
							pfx_d = 1'b0;
							if (rx > 8'd1) do_done = 1'b1;
							else begin
								wire_d = {1'b0, pcmd_q[6:0]};
								do_raw = 1'b1;
							end
						end else do_done = 1'b1;
					end
				end
				PH_CLK: begin
					bc_d = bc_q - 10'd1;
					if (bc_q - 10'd1 != 10'd0) begin
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end else begin
						do_cmd = 1'b1; cs_op = OP_RESET; cs_arg = '0; cs_k = K_CMD0;
					end
				end
				PH_OCR8: begin
					if (bc_q == 10'd2 && rx == 8'h01) ocr_d[0] = 1'b1;
					if (bc_q == 10'd3 && rx == 8'hAA) ocr_d[1] = 1'b1;
					bc_d = bc_q + 10'd1;
					if (bc_q + 10'd1 < 10'd4) begin
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end else if (ocr_d == 2'd3) begin
						retry_d = retry_lim_q; do_loop = 1'b1;
					end else do_init_fin = 1'b1;
				end
				PH_OCR58: begin
					if (bc_q == 10'd0) ocr_d = {1'b0, rx[6]};
					bc_d = bc_q + 10'd1;
					if (bc_q + 10'd1 < 10'd4) begin
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end else begin
						ikind_d = KIND_SD2 | (ocr_d[0] ? KIND_BLOCK : 4'h0);
						do_init_fin = 1'b1;
					end
				end
				PH_INIT_END: begin
					r.done_res = 1'b1; r.status = (ctype_q != 4'h0) ? ST_OK : ST_NOINIT;
					phase_d = PH_IDLE;
				end
				PH_TOKEN: begin
					pdec = poll_q - 16'd1;
					if (rx == 8'hFF) poll_d = pdec;
					if (rx == 8'hFF && pdec != 16'h0) begin
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end else if (rx != 8'hFE) do_err = 1'b1;
					else begin
						phase_d = PH_DATA; bc_d = '0; r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end
				end
				PH_DATA: begin
					if ({1'b0, bc_q} >= {2'b0, rdf_q} && {1'b0, bc_q} < rd_end) begin
						r.read_valid = 1'b1; r.read_byte = rx;
					end
					bcn = bc_q + 10'd1;
					bc_d = bcn;
					if ({1'b0, bcn} >= 11'(BLOCK_BYTES + 2)) begin
						cs_d = 1'b0; phase_d = PH_OK_END;
					end
					r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
				end
				PH_OK_END, PH_WS_TOKEN, PH_WB: begin
					r.done_res = 1'b1; r.status = ST_OK; phase_d = PH_IDLE;
				end
				PH_ERR_END: begin
					r.done_res = 1'b1; r.status = ST_ERR; phase_d = PH_IDLE;
				end
				PH_WF_PAD: begin
					bc_d = bc_q - 10'd1;
					if (bc_q - 10'd1 == 10'd0) phase_d = PH_WF_RESP;
					r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
				end
				PH_WF_RESP: begin
					if (rx[4:0] != 5'h05) do_err = 1'b1;
					else begin
						phase_d = PH_WF_BUSY; r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end
				end
				PH_WF_BUSY: begin
					if (rx != 8'h00) begin
						cs_d = 1'b0; phase_d = PH_OK_END;
					end
					r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
				end
				default: ;
			endcase
		end else if (q_item.command == CMD_TICK && phase_q == PH_TICK) begin
			retry_d = retry_q - 16'd1;
			do_loop = 1'b1;
		end

		// command completion dispatch
		if (do_done) begin
			case (ret_q)
				K_CMD0: begin
					if (resp == 8'd1) begin
						do_cmd = 1'b1; cs_op = OP_IFCOND; cs_arg = 32'h1AA; cs_k = K_CMD8;
					end else do_init_fin = 1'b1;
				end
				K_CMD8: begin
					if (resp == 8'd1) begin
						phase_d = PH_OCR8; bc_d = '0; ocr_d = '0;
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end else begin
						do_cmd = 1'b1; cs_op = OP_SD_INIT; cs_arg = '0; cs_k = K_PROBE;
					end
				end
				K_PROBE: begin
					ikind_d = (resp <= 8'd1) ? KIND_SD1 : KIND_MMC;
					retry_d = retry_lim_q; do_loop = 1'b1;
				end
				K_LOOP: begin
					if (resp != 8'd0) begin
						phase_d = PH_TICK; r.wait_tick = 1'b1;
					end else if (ikind_q == 4'h0) begin
						do_cmd = 1'b1; cs_op = OP_OCR; cs_arg = '0; cs_k = K_CMD58;
					end else begin
						do_cmd = 1'b1; cs_op = OP_BLKLEN; cs_arg = 32'(BLOCK_BYTES);
						cs_k = K_CMD16;
					end
				end
				K_CMD58: begin
					if (resp == 8'd0) begin
						phase_d = PH_OCR58; bc_d = '0; ocr_d = '0;
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end else do_init_fin = 1'b1;
				end
				K_CMD16: begin
					if (resp != 8'd0) ikind_d = '0;
					do_init_fin = 1'b1;
				end
				K_CMD17: begin
					if (resp != 8'd0) do_err = 1'b1;
					else begin
						phase_d = PH_TOKEN; poll_d = token_lim_q;
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end
				end
				default: begin
					if (resp != 8'd0) do_err = 1'b1;
					else begin
						wrem_d = 10'(BLOCK_BYTES); phase_d = PH_WS_TOKEN;
						r.tx_valid = 1'b1; r.tx_byte = 8'hFE;
					end
				end
			endcase
		end

		// init retry loop (ikind_d already holds the kind after probe)
		if (do_loop) begin
			if (retry_d == 16'h0) begin
				ikind_d = '0; do_init_fin = 1'b1;
			end else begin
				do_cmd = 1'b1; cs_k = K_LOOP;
				if (ikind_d == 4'h0) begin
					cs_op = OP_SD_INIT; cs_arg = 32'h4000_0000;
				end else if (ikind_d == KIND_SD1) begin
					cs_op = OP_SD_INIT; cs_arg = '0;
				end else begin
					cs_op = OP_MMC_INIT; cs_arg = '0;
				end
			end
		end

		if (do_cmd) begin
			pcmd_d = cs_op; parg_d = cs_arg; ret_d = cs_k; phase_d = PH_CMD;
			pfx_d = cs_op[7];
			wire_d = cs_op[7] ? OP_APP : cs_op;
			do_raw = 1'b1;
		end
		if (do_raw) begin
			sub_d = 4'd0; cs_d = 1'b0; r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
		end
		if (do_init_fin) begin
			ctype_d = ikind_d; cs_d = 1'b0; phase_d = PH_INIT_END;
			r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
		end
		if (do_err) begin
			cs_d = 1'b0; phase_d = PH_ERR_END; r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
		end
		r.chip_selected = cs_d;
		r.card_kind = ctype_d;
	end

	always_ff @(posedge clk) begin
		if (step) obuf_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_lim_q <= 8'd10; retry_lim_q <= 16'd10000; token_lim_q <= 16'd40000;
			phase_q <= PH_IDLE; sub_q <= '0; bc_q <= '0; poll_q <= '0; retry_q <= '0;
			ctype_q <= '0; ikind_q <= '0; pcmd_q <= '0; wire_q <= '0; parg_q <= '0;
			wrem_q <= '0; ocr_q <= '0; ret_q <= K_CMD0; rdf_q <= '0; rdc_q <= '0;
			pfx_q <= 1'b0; cs_q <= 1'b0; ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_POLL:  poll_lim_q <= cfg_data[7:0];
					REG_RETRY: retry_lim_q <= cfg_data;
					REG_TOKEN: token_lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (step) begin
				phase_q <= phase_d; sub_q <= sub_d; bc_q <= bc_d; poll_q <= poll_d;
				retry_q <= retry_d; ctype_q <= ctype_d; ikind_q <= ikind_d;
				pcmd_q <= pcmd_d; wire_q <= wire_d; parg_q <= parg_d; wrem_q <= wrem_d;
				ocr_q <= ocr_d; ret_q <= ret_d; rdf_q <= rdf_d; rdc_q <= rdc_d;
				pfx_q <= pfx_d; cs_q <= cs_d;
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end
endmodule

@@ design/sd_card_spi_host_sequencer_unit.sv @@
`timescale 1ns / 1ps
// SD card SPI-mode host sequencer.
// Input channel (in): host requests (init, read, write start/byte/finish),
// SPI receive bytes and 100 us delay ticks, one transaction per item.
// Output channel (out): exactly one result transaction per input item: the
// next SPI byte to exchange, chip select level, read data, tick request,
// done and status, and the detected card kind.
// Config port: cfg_we/cfg_idx/cfg_data; 0 poll limit, 1 init retries,
// 2 token wait limit. Write only while idle.
// Path: an item enters a 2-entry queue, is executed by the sequencer, and
// its result is registered in the output register: the queue entry and the
// output register lie between the accepting edge and out.valid. Throughput
// is one item per cycle while out.ready stays high.
// Stall: when out.ready is low the output register holds; the queue keeps
// taking up to two more items, then in.ready drops.
// Reset: asynchronous; card deselected, no card known, limits at defaults.
module sd_card_spi_host_sequencer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data,
	sdspi_in_if.sink   in,
	sdspi_out_if.source out
);
	import sdspi_pkg::*;

	logic      q_valid, q_ready;
	cls_item_t q_item;

	sdspi_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready), .in_item(in.payload),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	sdspi_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out.valid), .out_ready(out.ready), .out_item(out.payload)
	);
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import sdspi_pkg::*;

	localparam int unsigned TOTAL_ITEMS   = 1300;  // input transactions for the whole run
	localparam int unsigned MIN_QUARTER   = 30;    // smallest share of one random phase
	localparam int unsigned LONG_OP_ITEMS = 600;   // a full sector read or write
	localparam int unsigned IDLE_LIMIT    = 5000;  // cycles with no transaction at all
	localparam int unsigned TAIL_CYCLES   = 8;     // extra wait after the last expected result

	// card behaviors the responder can play
	localparam int CARD_SD2_BLOCK = 0;
	localparam int CARD_SD2_BYTE  = 1;
	localparam int CARD_SD1       = 2;
	localparam int CARD_MMC       = 3;
	localparam int CARD_DEAD      = 4;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [15:0] cfg_data;

	sdspi_in_if  in_ch ();
	sdspi_out_if out_ch ();

	sd_card_spi_host_sequencer_unit u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in(in_ch.sink), .out(out_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Sequencer predictor: mirrors the block's state, one step per item
	// ---------------------------------------------------------------
	logic [7:0]  lim_poll;
	logic [15:0] lim_retry, lim_token;
	phase_t      sq_phase;
	logic [3:0]  sq_sub;
	logic [9:0]  sq_bytes;
	logic [15:0] sq_poll, sq_retry;
	logic [3:0]  sq_card, sq_kind;
	logic [7:0]  sq_op, sq_wire;
	logic [31:0] sq_arg;
	logic [9:0]  sq_wr_left;
	logic [1:0]  sq_ocr;
	ret_t        sq_ret;
	int unsigned sq_rd_first, sq_rd_count;
	bit          sq_prefix, sq_cs;
	out_item_t   sq_res;

	function automatic void seq_reset();
		lim_poll = 8'd10; lim_retry = 16'd10000; lim_token = 16'd40000;
		sq_phase = PH_IDLE; sq_sub = '0; sq_bytes = '0; sq_poll = '0; sq_retry = '0;
		sq_card = '0; sq_kind = '0; sq_op = '0; sq_wire = '0; sq_arg = '0;
		sq_wr_left = '0; sq_ocr = '0; sq_ret = K_CMD0; sq_rd_first = 0;
		sq_rd_count = 0; sq_prefix = 0; sq_cs = 0;
	endfunction

	function automatic void seq_emit(logic [7:0] b);
		sq_res.tx_valid = 1'b1;
		sq_res.tx_byte = b;
	endfunction

	function automatic void seq_finish(logic [1:0] st);
		sq_res.done_res = 1'b1;
		sq_res.status = st;
		sq_phase = PH_IDLE;
	endfunction

	function automatic void seq_raw_begin();
		sq_sub = '0;
		sq_cs = 0;
		seq_emit(8'hFF);
	endfunction

	function automatic void seq_cmd_start(logic [7:0] op, logic [31:0] arg, ret_t k);
		sq_op = op;
		sq_arg = arg;
		sq_ret = k;
		sq_phase = PH_CMD;
		sq_prefix = op[7];   // ACMDs go out behind CMD55
		sq_wire = sq_prefix ? OP_APP : op;
		seq_raw_begin();
	endfunction

	function automatic logic [7:0] seq_frame_byte(logic [3:0] step);
		logic [31:0] arg;
		arg = sq_prefix ? 32'd0 : sq_arg;
		if (step == 4'd2) return sq_wire;
		if (step < 4'd7) return 8'(arg >> ((6 - step) * 8));
		if (sq_wire == OP_RESET) return 8'h95;
		if (sq_wire == OP_IFCOND) return 8'h87;
		return 8'h01;
	endfunction

	function automatic void seq_init_end();
		sq_card = sq_kind;
		sq_cs = 0;
		sq_phase = PH_INIT_END;
		seq_emit(8'hFF);
	endfunction

	function automatic void seq_err_end();
		sq_cs = 0;
		sq_phase = PH_ERR_END;
		seq_emit(8'hFF);
	endfunction

	function automatic void seq_try_init();
		if (sq_retry == 16'd0) begin
			sq_kind = '0;
			seq_init_end();
		end else if (sq_kind == 4'd0) begin
			seq_cmd_start(OP_SD_INIT, 32'h4000_0000, K_LOOP);
		end else if (sq_kind == KIND_SD1) begin
			seq_cmd_start(OP_SD_INIT, 32'd0, K_LOOP);
		end else begin
			seq_cmd_start(OP_MMC_INIT, 32'd0, K_LOOP);
		end
	endfunction

	function automatic void seq_response(logic [7:0] rsp);
		case (sq_ret)
			K_CMD0: begin
				if (rsp == 8'd1) seq_cmd_start(OP_IFCOND, 32'h1AA, K_CMD8);
				else seq_init_end();
			end
			K_CMD8: begin
				if (rsp == 8'd1) begin
					sq_phase = PH_OCR8; sq_bytes = '0; sq_ocr = '0; seq_emit(8'hFF);
				end else seq_cmd_start(OP_SD_INIT, 32'd0, K_PROBE);
			end
			K_PROBE: begin
				sq_kind = (rsp <= 8'd1) ? KIND_SD1 : KIND_MMC;
				sq_retry = lim_retry;
				seq_try_init();
			end
			K_LOOP: begin
				if (rsp != 8'd0) begin
					sq_phase = PH_TICK;
					sq_res.wait_tick = 1'b1;
				end else if (sq_kind == 4'd0) seq_cmd_start(OP_OCR, 32'd0, K_CMD58);
				else seq_cmd_start(OP_BLKLEN, BLOCK_BYTES, K_CMD16);
			end
			K_CMD58: begin
				if (rsp == 8'd0) begin
					sq_phase = PH_OCR58; sq_bytes = '0; sq_ocr = '0; seq_emit(8'hFF);
				end else seq_init_end();
			end
			K_CMD16: begin
				if (rsp != 8'd0) sq_kind = '0;
				seq_init_end();
			end
			K_CMD17: begin
				if (rsp != 8'd0) seq_err_end();
				else begin
					sq_phase = PH_TOKEN; sq_poll = lim_token; seq_emit(8'hFF);
				end
			end
			default: begin
				if (rsp != 8'd0) seq_err_end();
				else begin
					sq_wr_left = 10'(BLOCK_BYTES); sq_phase = PH_WS_TOKEN; seq_emit(8'hFE);
				end
			end
		endcase
	endfunction

	function automatic void seq_command_rx(logic [7:0] rx);
		if (sq_sub == 4'd0) begin
			sq_cs = 1; sq_sub = 4'd1; seq_emit(8'hFF);
		end else if (sq_sub < 4'd7) begin
			sq_sub++;
			seq_emit(seq_frame_byte(sq_sub));
		end else if (sq_sub == 4'd7) begin
			sq_sub = 4'd8; sq_poll = {8'd0, lim_poll}; seq_emit(8'hFF);
		end else begin
			// bit 7 set: card has not answered yet
			if (rx[7]) begin
				sq_poll = {8'd0, sq_poll[7:0] - 8'd1};
				if (sq_poll != 16'd0) begin
					seq_emit(8'hFF);
					return;
				end
			end
			if (sq_prefix) begin
				sq_prefix = 0;
				if (rx > 8'd1) begin
					seq_response(rx);
					return;
				end
				sq_wire = {1'b0, sq_op[6:0]};
				seq_raw_begin();
				return;
			end
			seq_response(rx);
		end
	endfunction

	function automatic logic [31:0] seq_address(logic [31:0] s);
		return (sq_card & KIND_BLOCK) != 0 ? s : s * BLOCK_BYTES;
	endfunction

	function automatic void seq_rx(logic [7:0] rx);
		case (sq_phase)
			PH_CMD: seq_command_rx(rx);
			PH_CLK: begin
				sq_bytes = sq_bytes - 10'd1;
				if (sq_bytes != 0) seq_emit(8'hFF);
				else seq_cmd_start(OP_RESET, 32'd0, K_CMD0);
			end
			PH_OCR8: begin
				// CMD8 echo: voltage byte then the check pattern
				if (sq_bytes == 10'd2 && rx == 8'h01) sq_ocr[0] = 1'b1;
				if (sq_bytes == 10'd3 && rx == 8'hAA) sq_ocr[1] = 1'b1;
				sq_bytes++;
				if (sq_bytes < 10'd4) seq_emit(8'hFF);
				else if (sq_ocr == 2'd3) begin
					sq_retry = lim_retry; seq_try_init();
				end else seq_init_end();
			end
			PH_OCR58: begin
				if (sq_bytes == 10'd0) sq_ocr = {1'b0, rx[6]};
				sq_bytes++;
				if (sq_bytes < 10'd4) seq_emit(8'hFF);
				else begin
					sq_kind = KIND_SD2 | (sq_ocr[0] ? KIND_BLOCK : 4'd0);
					seq_init_end();
				end
			end
			PH_INIT_END: seq_finish(sq_card != 0 ? ST_OK : ST_NOINIT);
			PH_TOKEN: begin
				if (rx == 8'hFF) begin
					sq_poll = sq_poll - 16'd1;
					if (sq_poll != 16'd0) begin
						seq_emit(8'hFF);
						return;
					end
				end
				if (rx != 8'hFE) seq_err_end();
				else begin
					sq_phase = PH_DATA; sq_bytes = '0; seq_emit(8'hFF);
				end
			end
			PH_DATA: begin
				if (sq_bytes >= sq_rd_first && sq_bytes < sq_rd_first + sq_rd_count) begin
					sq_res.read_valid = 1'b1;
					sq_res.read_byte = rx;
				end
				sq_bytes++;
				// 512 data bytes plus the two CRC bytes
				if (sq_bytes >= BLOCK_BYTES + 2) begin
					sq_cs = 0; sq_phase = PH_OK_END;
				end
				seq_emit(8'hFF);
			end
			PH_OK_END, PH_WS_TOKEN, PH_WB: seq_finish(ST_OK);
			PH_ERR_END: seq_finish(ST_ERR);
			PH_WF_PAD: begin
				sq_bytes = sq_bytes - 10'd1;
				if (sq_bytes == 0) sq_phase = PH_WF_RESP;
				seq_emit(8'hFF);
			end
			PH_WF_RESP: begin
				if (rx[4:0] != 5'h05) seq_err_end();
				else begin
					sq_phase = PH_WF_BUSY; seq_emit(8'hFF);
				end
			end
			PH_WF_BUSY: begin
				if (rx != 8'd0) begin
					sq_cs = 0; sq_phase = PH_OK_END;
				end
				seq_emit(8'hFF);
			end
			default: ;
		endcase
	endfunction

	function automatic void seq_request(in_item_t it);
		case (it.command)
			CMD_INIT: begin
				sq_kind = '0; sq_cs = 0; sq_bytes = 10'd10; sq_phase = PH_CLK; seq_emit(8'hFF);
			end
			CMD_READ: begin
				if (it.byte_offset + it.byte_count > BLOCK_BYTES) seq_finish(ST_ERR);
				else begin
					sq_rd_first = it.byte_offset;
					sq_rd_count = it.byte_count;
					seq_cmd_start(OP_READ, seq_address(it.sector), K_CMD17);
				end
			end
			CMD_WSTART: seq_cmd_start(OP_WRITE, seq_address(it.sector), K_CMD24);
			CMD_WBYTE: begin
				if (sq_wr_left == 0) seq_finish(ST_OK);
				else begin
					sq_wr_left--; sq_phase = PH_WB; seq_emit(it.data_byte);
				end
			end
			default: begin
				// finish pads the unsent rest plus the two CRC bytes
				sq_bytes = sq_wr_left + 10'd2; sq_wr_left = '0;
				sq_phase = PH_WF_PAD; seq_emit(8'hFF);
			end
		endcase
	endfunction

	function automatic out_item_t seq_step(in_item_t it);
		sq_res = '0;
		if (sq_phase == PH_IDLE && it.command <= CMD_WFINISH) seq_request(it);
		else if (it.command == CMD_RX && sq_phase != PH_IDLE && sq_phase != PH_TICK)
			seq_rx(it.rx_byte);
		else if (it.command == CMD_TICK && sq_phase == PH_TICK) begin
			sq_retry = sq_retry - 16'd1;
			seq_try_init();
		end
		sq_res.chip_selected = sq_cs;
		sq_res.card_kind = sq_card;
		return sq_res;
	endfunction

	// ---------------------------------------------------------------
	// Card model: answers each exchange from the predictor's view
	// ---------------------------------------------------------------
	int card_sel, busy_pct, garble_pct, loop_idle_pct, noise_pct;

	function automatic logic [7:0] card_reply();
		logic [7:0] b;
		b = 8'($urandom);
		case (sq_phase)
			PH_CMD: begin
				if (sq_sub < 4'd8) return b;
				if ($urandom_range(99) < busy_pct) return 8'hFF;
				if (sq_prefix) b = 8'h01;
				else case (sq_ret)
					K_CMD0:  b = (card_sel == CARD_DEAD) ? 8'h00 : 8'h01;
					K_CMD8:  b = (card_sel <= CARD_SD2_BYTE) ? 8'h01 : 8'h05;
					K_PROBE: b = (card_sel == CARD_MMC) ? 8'h05 : 8'h01;
					K_LOOP:  b = ($urandom_range(99) < loop_idle_pct) ? 8'h01 : 8'h00;
					default: b = 8'h00;
				endcase
			end
			PH_OCR8: begin
				if (sq_bytes == 10'd2) b = 8'h01;
				else if (sq_bytes == 10'd3) b = 8'hAA;
			end
			PH_OCR58: if (sq_bytes == 10'd0) b[6] = (card_sel == CARD_SD2_BLOCK);
			PH_TOKEN: b = ($urandom_range(99) < busy_pct) ? 8'hFF : 8'hFE;
			PH_WF_RESP: b[4:0] = 5'h05;
			PH_WF_BUSY: b = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 1));
			default: ;
		endcase
		if ($urandom_range(99) < garble_pct) b = 8'($urandom);
		return b;
	endfunction

	// ---------------------------------------------------------------
	// Sender, result checker, watchdog
	// ---------------------------------------------------------------
	out_item_t expected_q[$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned cyc = 0;
	int unsigned burst_left, real_items;

	function automatic in_item_t random_fields();
		in_item_t it;
		it.command = cmd_t'($urandom_range(7));
		it.sector = $urandom;
		it.byte_offset = 9'($urandom);
		it.byte_count = 10'($urandom_range(BLOCK_BYTES));
		it.data_byte = 8'($urandom);
		it.rx_byte = 8'($urandom);
		return it;
	endfunction

	// one input transaction; called at a rising edge, returns at the accepting edge
	task automatic send_item(in_item_t it, output out_item_t res);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(4, 1);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(24, 1);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		do @(posedge clk); while (!in_ch.ready);
		real_items++;
		res = seq_step(it);
		expected_q.push_back(res);
	endtask

	task automatic send_noise();
		in_item_t it;
		out_item_t ignored;
		bit live;
		it = random_fields();
		do begin
			it.command = cmd_t'($urandom_range(7));
			if (sq_phase == PH_IDLE) live = it.command <= CMD_WFINISH;
			else if (sq_phase == PH_TICK) live = it.command == CMD_TICK;
			else live = it.command == CMD_RX;
		end while (live);
		send_item(it, ignored);
	endtask

	// a host request, then every exchange and tick it asks for until done
	task automatic run_request(in_item_t req, output out_item_t cur);
		in_item_t it;
		send_item(req, cur);
		while (!cur.done_res && (cur.tx_valid || cur.wait_tick)) begin
			if ($urandom_range(99) < noise_pct) send_noise();
			it = random_fields();
			if (cur.tx_valid) begin
				it.command = CMD_RX;
				it.rx_byte = card_reply();
			end else it.command = CMD_TICK;
			send_item(it, cur);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_limits(logic [7:0] poll, logic [15:0] retry, logic [15:0] token);
		drain();
		cfg_we <= 1'b1; cfg_idx <= REG_POLL; cfg_data <= {8'd0, poll};
		@(posedge clk);
		cfg_idx <= REG_RETRY; cfg_data <= retry;
		@(posedge clk);
		cfg_idx <= REG_TOKEN; cfg_data <= token;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_poll = poll; lim_retry = retry; lim_token = token;
		@(posedge clk);
	endtask

	task automatic do_init(int kind);
		in_item_t it;
		out_item_t r;
		card_sel = kind;
		it = random_fields();
		it.command = CMD_INIT;
		run_request(it, r);
	endtask

	task automatic do_read(logic [31:0] sector, int unsigned off, int unsigned cnt);
		in_item_t it;
		out_item_t r;
		it = random_fields();
		it.command = CMD_READ;
		it.sector = sector;
		it.byte_offset = 9'(off);
		it.byte_count = 10'(cnt);
		run_request(it, r);
	endtask

	task automatic do_simple(cmd_t c, logic [31:0] sector, logic [7:0] data);
		in_item_t it;
		out_item_t r;
		it = random_fields();
		it.command = c;
		it.sector = sector;
		it.data_byte = data;
		run_request(it, r);
	endtask

	// receiver stall pattern: the mode follows bits 9:8 of cyc, mode 0 never stalls
	always @(posedge clk) begin
		cyc <= cyc + 1;
		case ((cyc >> 8) % 4)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= (cyc % 4) != 3;
			2: out_ch.ready <= $urandom_range(1);
			default: out_ch.ready <= (cyc % 7) < 2;
		endcase
	end

	always @(posedge clk) begin
		out_item_t exp_r, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction %p", got);
			end else begin
				exp_r = expected_q.pop_front();
				if (got.tx_valid !== exp_r.tx_valid || got.tx_byte !== exp_r.tx_byte ||
						got.chip_selected !== exp_r.chip_selected ||
						got.read_valid !== exp_r.read_valid ||
						got.read_byte !== exp_r.read_byte ||
						got.wait_tick !== exp_r.wait_tick ||
						got.done_res !== exp_r.done_res || got.status !== exp_r.status ||
						got.card_kind !== exp_r.card_kind) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p actual %p", exp_r, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sd_card_spi_host_sequencer_unit test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_stray_items();
		repeat (3) send_noise();
	endtask

	task automatic test_card_detection();
		do_init(CARD_DEAD);
		do_init(CARD_MMC);
		do_init(CARD_SD1);
		do_init(CARD_SD2_BLOCK);
	endtask

	task automatic test_read_window();
		do_read(32'hFFFF_FFFF, 511, 2);   // past the end of the sector
		do_init(CARD_SD2_BYTE);           // byte addressing wraps sector*512
		do_read(32'hFFFF_FFFF, 0, 512);
	endtask

	task automatic test_write_paths();
		do_simple(CMD_WBYTE, 32'd0, 8'h5A);   // nothing open yet
		do_simple(CMD_WFINISH, 32'd0, 8'h00); // finish with nothing open
		do_simple(CMD_WSTART, 32'hFFFF_FFFF, 8'h00);
		do_simple(CMD_WBYTE, 32'd0, 8'h00);
		do_simple(CMD_WBYTE, 32'd0, 8'hFF);
		do_simple(CMD_WFINISH, 32'd0, 8'h00);
	endtask

	task automatic random_phase(int unsigned target);
		int unsigned sel, off, n;
		bit room;
		while (real_items < target) begin
			// full sector reads and writes only while the share leaves room
			room = (real_items + LONG_OP_ITEMS) < target;
			sel = $urandom_range(99);
			if (sel < 20) do_init($urandom_range(CARD_DEAD));
			else if (sel < 35 && room) begin
				off = $urandom_range(BLOCK_BYTES - 1);
				n = ($urandom_range(4) == 0) ? $urandom_range(BLOCK_BYTES)
						: $urandom_range(BLOCK_BYTES - off);
				do_read($urandom, off, n);
			end else if (sel < 70) begin
				if (room && $urandom_range(4) != 0) do_simple(CMD_WSTART, $urandom, 8'h00);
				n = $urandom_range(20);
				repeat (n) do_simple(CMD_WBYTE, 32'd0, 8'($urandom));
				if ($urandom_range(3) != 0) do_simple(CMD_WFINISH, 32'd0, 8'h00);
			end else begin
				send_noise();
			end
			// let everything come back before the next request now and then
			if ($urandom_range(15) == 0) drain();
		end
	endtask

	task automatic test_random_traffic();
		int unsigned quarter;
		busy_pct = 25; garble_pct = 6; loop_idle_pct = 35; noise_pct = 5;
		quarter = (real_items + 4 * MIN_QUARTER < TOTAL_ITEMS)
				? (TOTAL_ITEMS - real_items) / 4 : MIN_QUARTER;
		write_limits(8'd255, 16'hFFFF, 16'hFFFF);
		random_phase(real_items + quarter);
		write_limits(8'd1, 16'd1, 16'd1);
		random_phase(real_items + quarter);
		write_limits(8'($urandom_range(6, 2)), 16'($urandom_range(5, 2)),
				16'($urandom_range(8, 2)));
		random_phase(real_items + quarter);
		write_limits(8'd10, 16'd10000, 16'd40000);
		random_phase(real_items + quarter);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		burst_left = 0; real_items = 0;
		busy_pct = 20; garble_pct = 0; loop_idle_pct = 40; noise_pct = 0;
		seq_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stray_items();
		test_card_detection();
		test_read_window();
		test_write_paths();
		test_random_traffic();

		drain();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("sd_card_spi_host_sequencer_unit test passed");
		else
			$display("sd_card_spi_host_sequencer_unit test failed");
		$finish;
	end
endmodule
